// ----- design/rbs_pkg.sv -----
// ----------------------------------------------------------------------------
// rbs_pkg
// shared types and constants of the rotate bilinear sampler
// ----------------------------------------------------------------------------
`default_nettype none

package rbs_pkg;

	localparam int QBITS     = 14;  // fraction bits of the rotated coordinate
	localparam int FRAC_BITS = 8;   // fraction bits used for blending
	localparam int DIM_W     = 13;  // image dimension width, covers 4096
	localparam int TRIG_W    = 16;  // cosine and sine width
	localparam int IDX_W     = 8;   // config register index width
	localparam int QDEPTH    = 4;   // front queue depth
	localparam int QPTR_W    = 2;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	localparam logic [IDX_W-1:0] REG_WIDTH  = 8'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 8'd1;
	localparam logic [IDX_W-1:0] REG_COS    = 8'd2;
	localparam logic [IDX_W-1:0] REG_SIN    = 8'd3;

	localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;
	localparam logic signed [TRIG_W-1:0] SIN_RESET = 16'sd0;

	typedef struct packed {
		logic       op;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rbs_item_t;

	typedef struct packed {
		logic        [DIM_W-1:0]  width;
		logic        [DIM_W-1:0]  height;
		logic signed [TRIG_W-1:0] cos_q;
		logic signed [TRIG_W-1:0] sin_q;
	} rbs_cfg_t;

endpackage

`default_nettype wire

// ----- design/rbs_ram.sv -----
// ----------------------------------------------------------------------------
// rbs_ram
// generic simple dual port ram, one write port, registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  wire                                  clk,
	input  wire                                  we,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                      wdata,
	input  wire                                  re,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- design/rbs_front.sv -----
// ----------------------------------------------------------------------------
// rbs_front
// accepts beats, drops loads outside the store, queues the rest
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_front import rbs_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [39:0] s_tdata,
	input  wire        s_tuser,
	output logic       q_valid,
	input  wire        q_ready,
	output rbs_item_t  q_item
);

	rbs_item_t         item_c;
	logic              in_range_c;
	logic              push_c;
	logic              pop_c;
	rbs_item_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign item_c.op    = s_tuser;
	assign item_c.pos_x = s_tdata[7:0];
	assign item_c.pos_y = s_tdata[15:8];
	assign item_c.red   = s_tdata[23:16];
	assign item_c.green = s_tdata[31:24];
	assign item_c.blue  = s_tdata[39:32];

	assign in_range_c = (32'(item_c.pos_x) < MAX_WIDTH) && (32'(item_c.pos_y) < MAX_HEIGHT);
	assign s_tready   = (count_q != (QPTR_W+1)'(QDEPTH));
	assign push_c     = s_tvalid && s_tready && ((item_c.op == OP_COMPUTE) || in_range_c);
	assign q_valid    = (count_q != '0);
	assign pop_c      = q_valid && q_ready;
	assign q_item     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_c) begin
			mem_q[wr_ptr_q] <= item_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_c) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_c) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push_c && !pop_c) begin
				count_q <= count_q + 1'b1;
			end else if (pop_c && !push_c) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/rbs_back.sv -----
// ----------------------------------------------------------------------------
// rbs_back
// rotation, clamping, banked frame store and bilinear blend pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_back import rbs_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  rbs_item_t  in_item,
	input  rbs_cfg_t   cfg,
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [39:0] m_tdata
);

	localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
	localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
	localparam int BANK_DEPTH = HALF_W * HALF_H;
	localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int CW         = DIM_W + QBITS;
	localparam int PW         = TRIG_W + DIM_W + 1;
	localparam int LW         = 2 * DIM_W;

	logic en;

	// stage 1: offsets from centre and the four products
	logic [DIM_W-1:0]        cx_c, cy_c;
	logic signed [DIM_W:0]   dx_c, dy_c;
	logic signed [PW-1:0]    cdx_c, sdy_c, sdx_c, cdy_c;
	logic                    v_s1, op_s1;
	logic [7:0]              x_s1, y_s1;
	logic [23:0]             rgb_s1;
	logic signed [PW-1:0]    cdx_s1, sdy_s1, sdx_s1, cdy_s1;

	assign en = !m_tvalid || m_tready;
	assign in_ready = en;

	assign cx_c  = cfg.width >> 1;
	assign cy_c  = cfg.height >> 1;
	assign dx_c  = $signed({6'b0, in_item.pos_x}) - $signed({1'b0, cx_c});
	assign dy_c  = $signed({6'b0, in_item.pos_y}) - $signed({1'b0, cy_c});
	assign cdx_c = cfg.cos_q * dx_c;
	assign sdy_c = cfg.sin_q * dy_c;
	assign sdx_c = cfg.sin_q * dx_c;
	assign cdy_c = cfg.cos_q * dy_c;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= in_item.op;
			x_s1   <= in_item.pos_x;
			y_s1   <= in_item.pos_y;
			rgb_s1 <= {in_item.red, in_item.green, in_item.blue};
			cdx_s1 <= cdx_c;
			sdy_s1 <= sdy_c;
			sdx_s1 <= sdx_c;
			cdy_s1 <= cdy_c;
		end
	end

	// stage 2: sum, recentre and clamp to the image
	logic signed [31:0] rx_raw_c, ry_raw_c, hx_c, hy_c, rx_cl_c, ry_cl_c;
	logic               v_s2, op_s2;
	logic [7:0]         x_s2, y_s2;
	logic [23:0]        rgb_s2;
	logic [CW-1:0]      rx_s2, ry_s2;

	assign rx_raw_c = 32'(cdx_s1) - 32'(sdy_s1) + $signed({5'b0, cx_c, 14'b0});
	assign ry_raw_c = 32'(sdx_s1) + 32'(cdy_s1) + $signed({5'b0, cy_c, 14'b0});
	assign hx_c     = $signed({5'b0, cfg.width - 1'b1, 14'b0});
	assign hy_c     = $signed({5'b0, cfg.height - 1'b1, 14'b0});
	assign rx_cl_c  = (rx_raw_c < 0) ? 32'sd0 : ((rx_raw_c > hx_c) ? hx_c : rx_raw_c);
	assign ry_cl_c  = (ry_raw_c < 0) ? 32'sd0 : ((ry_raw_c > hy_c) ? hy_c : ry_raw_c);

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2  <= op_s1;
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			rgb_s2 <= rgb_s1;
			rx_s2  <= rx_cl_c[CW-1:0];
			ry_s2  <= ry_cl_c[CW-1:0];
		end
	end

	// stage 2 to 3: four parity banks, each neighbor in a bank of its own
	logic [DIM_W-1:0] x0_c, y0_c, x1_c, y1_c;
	logic [DIM_W-1:0] wx_c, wy_c;
	logic [LW-1:0]    wlin_c;
	logic [23:0]      rd_c [4];

	assign x0_c   = rx_s2[CW-1:QBITS];
	assign y0_c   = ry_s2[CW-1:QBITS];
	assign x1_c   = x0_c + 1'b1;
	assign y1_c   = y0_c + 1'b1;
	assign wx_c   = {5'b0, x_s2};
	assign wy_c   = {5'b0, y_s2};
	assign wlin_c = LW'(wy_c[DIM_W-1:1]) * LW'(HALF_W) + LW'(wx_c[DIM_W-1:1]);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [DIM_W-1:0] xa_c, ya_c;
		logic [LW-1:0]    rlin_c;
		logic             we_c;

		assign xa_c   = (x0_c[0] == b[0]) ? x0_c : x1_c;
		assign ya_c   = (y0_c[0] == b[1]) ? y0_c : y1_c;
		assign rlin_c = LW'(ya_c[DIM_W-1:1]) * LW'(HALF_W) + LW'(xa_c[DIM_W-1:1]);
		assign we_c   = en && v_s2 && (op_s2 == OP_LOAD) && (x_s2[0] == b[0])
			&& (y_s2[0] == b[1]);

		rbs_ram #(
			.WIDTH(24),
			.DEPTH(BANK_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (we_c),
			.waddr(wlin_c[BAW-1:0]),
			.wdata(rgb_s2),
			.re   (en),
			.raddr(rlin_c[BAW-1:0]),
			.rdata(rd_c[b])
		);
	end

	logic                 v_s3, op_s3;
	logic [7:0]           x_s3, y_s3;
	logic [FRAC_BITS-1:0] fx_s3, fy_s3;
	logic                 x0p_s3, y0p_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3  <= op_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			fx_s3  <= rx_s2[QBITS-1:QBITS-FRAC_BITS];
			fy_s3  <= ry_s2[QBITS-1:QBITS-FRAC_BITS];
			x0p_s3 <= x0_c[0];
			y0p_s3 <= y0_c[0];
		end
	end

	// stage 3: pick neighbors by parity, weights
	logic [23:0] p00_c, px_c, py_c, pxy_c, p01_c, p10_c, p11_c;
	logic [8:0]  ax_c, ay_c;
	logic        fxz_c, fyz_c;
	logic        v_s4, op_s4;
	logic [7:0]  x_s4, y_s4;
	logic [16:0] w_s4 [4];
	logic [23:0] p_s4 [4];

	assign p00_c = rd_c[{y0p_s3, x0p_s3}];
	assign px_c  = rd_c[{y0p_s3, !x0p_s3}];
	assign py_c  = rd_c[{!y0p_s3, x0p_s3}];
	assign pxy_c = rd_c[{!y0p_s3, !x0p_s3}];
	assign fxz_c = (fx_s3 == '0);
	assign fyz_c = (fy_s3 == '0);
	// a zero fraction means the far neighbor is the near one
	assign p01_c = fxz_c ? p00_c : px_c;
	assign p10_c = fyz_c ? p00_c : py_c;
	assign p11_c = fyz_c ? p01_c : (fxz_c ? py_c : pxy_c);
	assign ax_c  = 9'd256 - {1'b0, fx_s3};
	assign ay_c  = 9'd256 - {1'b0, fy_s3};

	always_ff @(posedge clk) begin
		if (en) begin
			op_s4   <= op_s3;
			x_s4    <= x_s3;
			y_s4    <= y_s3;
			w_s4[0] <= 17'(ax_c * ay_c);
			w_s4[1] <= 17'({1'b0, fx_s3} * ay_c);
			w_s4[2] <= 17'(ax_c * {1'b0, fy_s3});
			w_s4[3] <= 17'({1'b0, fx_s3} * {1'b0, fy_s3});
			p_s4[0] <= p00_c;
			p_s4[1] <= p01_c;
			p_s4[2] <= p10_c;
			p_s4[3] <= p11_c;
		end
	end

	// stage 4: weighted channel products
	logic        v_s5, op_s5;
	logic [7:0]  x_s5, y_s5;
	logic [24:0] pr_s5 [3][4];

	always_ff @(posedge clk) begin
		if (en) begin
			op_s5 <= op_s4;
			x_s5  <= x_s4;
			y_s5  <= y_s4;
			for (int c = 0; c < 3; c++) begin
				for (int k = 0; k < 4; k++) begin
					pr_s5[c][k] <= 25'(w_s4[k] * p_s4[k][16-8*c +: 8]);
				end
			end
		end
	end

	// stage 5: sum and truncate into the output register
	logic [25:0] acc_c [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc_c[c] = 26'(pr_s5[c][0]) + 26'(pr_s5[c][1]) + 26'(pr_s5[c][2])
				+ 26'(pr_s5[c][3]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {acc_c[2][23:16], acc_c[1][23:16], acc_c[0][23:16], y_s5, x_s5};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1     <= in_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			m_tvalid <= v_s5 && (op_s5 == OP_COMPUTE);
		end
	end

endmodule

`default_nettype wire

// ----- design/rotate_bilinear_sampler_unit.sv -----
// ----------------------------------------------------------------------------
// rotate_bilinear_sampler_unit
// rotates an rgb image about its centre with bilinear sampling
// ----------------------------------------------------------------------------
//
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   tdata pixel beat, tuser opcode
// m_*      out  m_tvalid/m_tready   tdata interpolated pixel beat
// cfg_*    in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// one beat per cycle sustained while m_tready does not stall the back; a compute beat
// leaves the queue head and reaches m_tdata through the five stage blend pipeline
// and the registered read of the four parity banked frame store
// the frame store has no clearing pass and is usable right after reset
// a stall on m_tready freezes the whole back pipeline; the input queue
// keeps taking beats until its four entries are full
//
`default_nettype none

module rotate_bilinear_sampler_unit import rbs_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	output logic             s_tready,
	input  wire [39:0]       s_tdata,    // pos_x, pos_y, in_red, in_green, in_blue
	input  wire              s_tuser,    // opcode
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [39:0]      m_tdata,    // out_x, out_y, out_red, out_green, out_blue
	input  wire              cfg_valid,
	output logic             cfg_ready,
	input  wire [IDX_W-1:0]  cfg_index,
	input  wire [15:0]       cfg_data
);

	localparam int RST_W = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
	localparam int RST_H = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

	rbs_cfg_t         cfg_q;
	logic             cfg_we;
	logic [8:0]       dim_raw;
	logic [DIM_W-1:0] eff_w, eff_h;
	logic             q_valid, q_ready;
	rbs_item_t        q_item;

	// registers are always writable
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign dim_raw   = cfg_data[8:0];

	// effective dimensions: zero reads as one, above the store saturates
	assign eff_w = (dim_raw == '0) ? DIM_W'(1)
		: ((32'(dim_raw) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : DIM_W'(dim_raw));
	assign eff_h = (dim_raw == '0) ? DIM_W'(1)
		: ((32'(dim_raw) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : DIM_W'(dim_raw));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= DIM_W'(RST_W);
			cfg_q.height <= DIM_W'(RST_H);
			cfg_q.cos_q  <= COS_RESET;
			cfg_q.sin_q  <= SIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  cfg_q.width  <= eff_w;
				REG_HEIGHT: cfg_q.height <= eff_h;
				REG_COS:    cfg_q.cos_q  <= $signed(cfg_data);
				REG_SIN:    cfg_q.sin_q  <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// front: take beats, drop loads outside the store, queue the rest
	rbs_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item)
	);

	// back: store writes, rotation and blend
	rbs_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(q_valid),
		.in_ready(q_ready),
		.in_item (q_item),
		.cfg     (cfg_q),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

`ifndef SYNTH
	// a stalled result freezes the back, so the queue must not drain
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !(q_valid && q_ready))
		else $error("queue popped while output stalled");

	// every accepted compute beat lands in the queue
	a_compute_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == OP_COMPUTE)) |=> q_valid)
		else $error("compute beat lost before queue");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb_rotate_bilinear_sampler_unit.sv -----
// ----------------------------------------------------------------------------
// tb_rotate_bilinear_sampler_unit
// self-checking bench for the rotating bilinear sampler
// ----------------------------------------------------------------------------
// A short directed table loads corner pixels and samples them back at reset
// geometry. The run then steps through a set of image sizes and angles: small
// images are filled completely, and full-size images use an identity angle
// restricted to pixels already loaded. Each phase mixes random compute and load
// beats. A rotation and blend model inside the bench predicts every output
// pixel. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rotate_bilinear_sampler_unit;
	import rbs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_W   = 256;
	localparam int STORE_H   = 256;
	localparam int CYCLE_CAP = 1_000_000;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} out_pixel_t;

	// directed row: beat plus optional typed-in expected color
	typedef struct {
		logic       op;
		logic [7:0] x;
		logic [7:0] y;
		logic [23:0] rgb;
		bit         typed;
		logic [23:0] want;
	} stim_row_t;

	// angle and size setting of one phase
	typedef struct {
		logic [15:0] width;
		logic [15:0] height;
		logic [15:0] cos_v;
		logic [15:0] sin_v;
		int          ready_pct;
	} phase_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [15:0] cfg_data;

	rotate_bilinear_sampler_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // pos_x, pos_y, in_red, in_green, in_blue
		.s_tuser   (s_tuser),    // opcode
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),    // out_x, out_y, out_red, out_green, out_blue
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// bench copy of the frame store and the registers
	logic [23:0] pixel_mem [STORE_W*STORE_H];
	bit          pixel_seen [STORE_W*STORE_H];
	int          seen_addr_q [$];
	logic [8:0]  img_w_reg, img_h_reg;
	logic signed [15:0] cos_reg, sin_reg;

	out_pixel_t  pending_px_q [$];
	int          mismatches;
	int          cycles;
	int          ready_pct;
	int          burst_left;
	bit          failed;

	// clock and cycle limit
	always begin
		clk = 1'b0; #6;
		clk = 1'b1; #6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver stalls on its own random duty
	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) < ready_pct);

	// output beat check against the oldest predicted pixel
	always @(posedge clk) begin
		out_pixel_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = out_pixel_t'({m_tdata[39:32], m_tdata[31:24], m_tdata[23:16],
				m_tdata[15:8], m_tdata[7:0]});
			// struct order is x first; unpack by field, lowest bits first
			got.x     = m_tdata[7:0];
			got.y     = m_tdata[15:8];
			got.red   = m_tdata[23:16];
			got.green = m_tdata[31:24];
			got.blue  = m_tdata[39:32];
			if (pending_px_q.size() == 0) begin
				failed = 1'b1;
				if (mismatches < 10)
					$display("unexpected output beat %h", m_tdata);
				mismatches++;
			end else begin
				want = pending_px_q.pop_front();
				if (got !== want) begin
					failed = 1'b1;
					if (mismatches < 10)
						$display("pixel mismatch exp x=%0d y=%0d rgb=%h%h%h got x=%0d y=%0d rgb=%h%h%h",
							want.x, want.y, want.red, want.green, want.blue,
							got.x, got.y, got.red, got.green, got.blue);
					mismatches++;
				end
			end
		end
	end

	// clamp a q.14 coordinate to the image span
	function automatic int clamp_coord(int v, int dim);
		int hi;
		hi = (dim - 1) << QBITS;
		if (v < 0) return 0;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int eff_size(logic [8:0] raw);
		int d;
		d = int'(raw);
		if (d < 1) d = 1;
		if (d > 256) d = 256;
		return d;
	endfunction

	// rotate the output position back into the source and blend four neighbors
	function automatic out_pixel_t rotate_sample(logic [7:0] px, logic [7:0] py);
		int w, h, cx, cy, c, s, rx, ry, x0, y0, x1, y1, fx, fy, acc, sh;
		int wt [4];
		logic [23:0] nb [4];
		out_pixel_t r;
		w  = eff_size(img_w_reg);
		h  = eff_size(img_h_reg);
		cx = w / 2;
		cy = h / 2;
		c  = int'(cos_reg);
		s  = int'(sin_reg);
		rx = clamp_coord(c * (int'(px) - cx) - s * (int'(py) - cy) + (cx << QBITS), w);
		ry = clamp_coord(s * (int'(px) - cx) + c * (int'(py) - cy) + (cy << QBITS), h);
		x0 = rx >> QBITS;
		y0 = ry >> QBITS;
		fx = (rx >> (QBITS - FRAC_BITS)) & 255;
		fy = (ry >> (QBITS - FRAC_BITS)) & 255;
		x1 = x0 + int'(fx != 0);
		y1 = y0 + int'(fy != 0);
		wt[0] = (256 - fx) * (256 - fy);
		wt[1] = fx * (256 - fy);
		wt[2] = (256 - fx) * fy;
		wt[3] = fx * fy;
		nb[0] = pixel_mem[y0*STORE_W + x0];
		nb[1] = pixel_mem[y0*STORE_W + x1];
		nb[2] = pixel_mem[y1*STORE_W + x0];
		nb[3] = pixel_mem[y1*STORE_W + x1];
		r.x = px;
		r.y = py;
		for (int ch = 0; ch < 3; ch++) begin
			sh  = 16 - 8 * ch;
			acc = 0;
			for (int k = 0; k < 4; k++)
				acc += wt[k] * ((nb[k] >> sh) & 255);
			acc = (acc >> 16) & 255;
			case (ch)
				0: r.red   = 8'(acc);
				1: r.green = 8'(acc);
				default: r.blue = 8'(acc);
			endcase
		end
		return r;
	endfunction

	// one input beat: bursty sender, prediction on acceptance
	task automatic push_beat(logic op, logic [7:0] px, logic [7:0] py,
		logic [23:0] rgb, bit typed, logic [23:0] want);
		int gap, a;
		out_pixel_t e;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
		end
		burst_left--;
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16], py, px};
		do @(posedge clk); while (!s_tready);
		a = int'(py) * STORE_W + int'(px);
		if (op == OP_LOAD) begin
			pixel_mem[a] = rgb;
			if (!pixel_seen[a]) begin
				pixel_seen[a] = 1'b1;
				seen_addr_q.push_back(a);
			end
		end else begin
			e = rotate_sample(px, py);
			if (typed) {e.red, e.green, e.blue} = want;
			pending_px_q.push_back(e);
		end
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [15:0] val);
		@(negedge clk);
		s_tvalid  <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WIDTH:  img_w_reg = val[8:0];
			REG_HEIGHT: img_h_reg = val[8:0];
			REG_COS:    cos_reg   = val;
			REG_SIN:    sin_reg   = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drain outstanding pixels, then let trailing loads settle
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_px_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	stim_row_t directed [] = '{
		'{OP_LOAD,    8'd0,   8'd0,   24'hFFFFFF, 1'b0, 24'h0},
		'{OP_LOAD,    8'd255, 8'd255, 24'h000000, 1'b0, 24'h0},
		'{OP_LOAD,    8'd255, 8'd0,   24'hFF00A5, 1'b0, 24'h0},
		'{OP_LOAD,    8'd0,   8'd255, 24'h5A0FF0, 1'b0, 24'h0},
		'{OP_LOAD,    8'd128, 8'd128, 24'h123456, 1'b0, 24'h0},
		// identity angle at reset: each sample lands on its own pixel
		'{OP_COMPUTE, 8'd0,   8'd0,   24'hA5A5A5, 1'b1, 24'hFFFFFF},
		'{OP_COMPUTE, 8'd255, 8'd255, 24'h000000, 1'b1, 24'h000000},
		'{OP_COMPUTE, 8'd255, 8'd0,   24'hFFFFFF, 1'b1, 24'hFF00A5},
		'{OP_COMPUTE, 8'd0,   8'd255, 24'h000000, 1'b1, 24'h5A0FF0},
		'{OP_COMPUTE, 8'd128, 8'd128, 24'h000000, 1'b1, 24'h123456},
		'{OP_LOAD,    8'd128, 8'd128, 24'hEDCBA9, 1'b0, 24'h0},
		'{OP_COMPUTE, 8'd128, 8'd128, 24'h000000, 1'b1, 24'hEDCBA9}
	};

	// width 0 and 511 exercise the size saturation, 0x8000 the raw trig range
	phase_t phases [] = '{
		'{16'd4,   16'd3,   16'd11585, 16'd11585, 100},
		'{16'd0,   16'd0,   16'hC000,  16'd0,     60},
		'{16'd16,  16'd16,  16'd0,     16'd16384, 100},
		'{16'd511, 16'd300, 16'd16384, 16'd0,     40},
		'{16'd13,  16'd7,   16'h8000,  16'h7FFF,  80},
		'{16'd1,   16'd256, 16'd5000,  16'hDCD8,  100},
		'{16'd16,  16'd24,  16'h2D41,  16'hC000,  25},
		'{16'd256, 16'd256, 16'd16384, 16'd0,     90},
		'{16'd9,   16'd5,   16'hF0A0,  16'h1F00,  100}
	};

	initial begin
		int w, h, a;
		bit full_size;
		logic [7:0] rx, ry;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = OP_LOAD;
		m_tready   = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		cycles     = 0;
		mismatches = 0;
		failed     = 1'b0;
		burst_left = 0;
		ready_pct  = 100;
		img_w_reg  = 9'd256;
		img_h_reg  = 9'd256;
		cos_reg    = COS_RESET;
		sin_reg    = SIN_RESET;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			push_beat(directed[i].op, directed[i].x, directed[i].y,
				directed[i].rgb, directed[i].typed, directed[i].want);

		foreach (phases[p]) begin
			wait_idle();
			ready_pct = phases[p].ready_pct;
			write_reg(REG_WIDTH,  phases[p].width);
			write_reg(REG_HEIGHT, phases[p].height);
			write_reg(REG_COS,    phases[p].cos_v);
			write_reg(REG_SIN,    phases[p].sin_v);
			w = eff_size(img_w_reg);
			h = eff_size(img_h_reg);
			// large images run at identity and sample only loaded pixels
			full_size = (w * h > 4096);
			if (!full_size)
				for (int yy = 0; yy < h; yy++)
					for (int xx = 0; xx < w; xx++)
						if (!pixel_seen[yy*STORE_W + xx])
							push_beat(OP_LOAD, 8'(xx), 8'(yy), 24'($urandom),
								1'b0, 24'h0);
			for (int n = 0; n < 58; n++) begin
				rx = 8'($urandom);
				ry = 8'($urandom);
				if ($urandom_range(0, 3) == 0) begin
					push_beat(OP_LOAD, rx, ry, 24'($urandom), 1'b0, 24'h0);
				end else begin
					if (full_size) begin
						a  = seen_addr_q[$urandom_range(0, seen_addr_q.size() - 1)];
						rx = 8'(a % STORE_W);
						ry = 8'(a / STORE_W);
					end
					push_beat(OP_COMPUTE, rx, ry, 24'($urandom), 1'b0, 24'h0);
				end
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (!failed && pending_px_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
